FILE: src/e2lc_pkg.sv
// ----------------------------------------------------------------------------
// e2lc_pkg - shared types and constants for the epoch to calendar converter
// Field widths, controller states, datapath operations and the month table.
// ----------------------------------------------------------------------------
`default_nettype none

package e2lc_pkg;

	// field widths
	localparam int EPOCH_W  = 32;
	localparam int OFFSET_W = 17;
	localparam int YEAR_W   = 11;
	localparam int MONTH_W  = 4;
	localparam int MDAY_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int WDAY_W   = 3;
	localparam int YDAY_W   = 9;

	// working widths
	localparam int NUM_W   = 33;  // biased seconds, always positive
	localparam int DAYS_W  = 16;  // days since 1901-01-01
	localparam int SOD_W   = 17;  // seconds of the day
	localparam int SOH_W   = 12;  // seconds of the hour
	localparam int HPROD_W = 34;
	localparam int MPROD_W = 25;

	// a day is 675 << 7 seconds: drop the low 7 bits, then divide by 675
	localparam int DAY_PRESHIFT = 7;
	localparam int DAYX_W       = NUM_W - DAY_PRESHIFT;
	localparam int DPROD_W      = 53;
	localparam int WPROD_W      = 33;
	localparam int WQ_W         = 14;

	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd28800;

	// 1901-01-01 lies 25202 days before 1970-01-01 and was a Tuesday
	localparam logic [33:0]        EPOCH_BIAS   = 34'd2177452800;
	localparam logic [YEAR_W-1:0]  BASE_YEAR    = 11'd1901;
	localparam logic [2:0]         BASE_WEEKDAY = 3'd2;

	localparam logic [SOD_W-1:0]   SEC_PER_DAY  = 17'd86400;
	localparam logic [SOD_W-1:0]   SEC_PER_HOUR = 17'd3600;
	localparam logic [SOH_W-1:0]   SEC_PER_MIN  = 12'd60;
	localparam logic [DAYS_W-1:0]  DAYS_PER_4Y  = 16'd1461;
	localparam logic [DAYS_W-1:0]  DAYS_PER_WEEK = 16'd7;

	// floor(x * RECIP >> SHIFT) is exact over the whole input range
	localparam logic [26:0]        DAY_RECIP    = 27'd101806633;
	localparam int                 DAY_SHIFT    = 36;
	localparam logic [16:0]        WDAY_RECIP   = 17'd74899;
	localparam int                 WDAY_SHIFT   = 19;
	localparam logic [SOD_W-1:0]   HOUR_RECIP   = 17'd74566;
	localparam int                 HOUR_SHIFT   = 28;
	localparam logic [12:0]        MIN_RECIP    = 13'd4370;
	localparam int                 MIN_SHIFT    = 18;

	localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DMUL,
		ST_DSPLIT,
		ST_HMUL,
		ST_HSPLIT,
		ST_MMUL,
		ST_MSPLIT,
		ST_YR4,
		ST_YR1,
		ST_MON,
		ST_FINISH
	} e2lc_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DMUL,
		OP_DSPLIT,
		OP_HMUL,
		OP_HSPLIT,
		OP_MMUL,
		OP_MSPLIT,
		OP_YR4,
		OP_YR1,
		OP_MON,
		OP_OUT
	} e2lc_op_t;

	typedef struct packed {
		e2lc_op_t op;
	} e2lc_cmd_t;

	typedef struct packed {
		logic yr4_more;
		logic yr1_more;
		logic mon_more;
	} e2lc_sts_t;

	function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [MDAY_W-1:0] len;
		begin
			case (m)
				4'd1:                      len = leap ? 5'd29 : 5'd28;
				4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
				default:                   len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/e2lc_if.sv
// ----------------------------------------------------------------------------
// e2lc interfaces - input, result and offset channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2lc_in_if;
	import e2lc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [EPOCH_W-1:0]  epoch_seconds;
	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2lc_cfg_if;
	import e2lc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [OFFSET_W-1:0] utc_offset_seconds;
	modport source (output valid, output utc_offset_seconds, input ready);
	modport sink   (input valid, input utc_offset_seconds, output ready);
endinterface

interface e2lc_out_if;
	import e2lc_pkg::*;
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [MDAY_W-1:0]   day_of_month;
	logic [HOUR_W-1:0]   hour;
	logic [MIN_W-1:0]    minute;
	logic [SEC_W-1:0]    second;
	logic [WDAY_W-1:0]   weekday;
	logic [YDAY_W-1:0]   day_of_year;
	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output weekday,
		output day_of_year, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input weekday,
		input day_of_year, output ready);
endinterface

`default_nettype wire

FILE: src/e2lc_ctrl.sv
// ----------------------------------------------------------------------------
// e2lc_ctrl - conversion sequencer
// Steps the datapath through divide, time split, year walk and month walk.
// ----------------------------------------------------------------------------
`default_nettype none

module e2lc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output e2lc_pkg::e2lc_cmd_t   cmd,
	input  wire e2lc_pkg::e2lc_sts_t sts
);
	import e2lc_pkg::*;

	e2lc_state_t       state_q, state_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_NONE;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q & ~out_ready;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DMUL;
				end
			end
			ST_DMUL: begin
				cmd.op  = OP_DMUL;
				state_d = ST_DSPLIT;
			end
			ST_DSPLIT: begin
				cmd.op  = OP_DSPLIT;
				state_d = ST_HMUL;
			end
			ST_HMUL: begin
				cmd.op  = OP_HMUL;
				state_d = ST_HSPLIT;
			end
			ST_HSPLIT: begin
				cmd.op  = OP_HSPLIT;
				state_d = ST_MMUL;
			end
			ST_MMUL: begin
				cmd.op  = OP_MMUL;
				state_d = ST_MSPLIT;
			end
			ST_MSPLIT: begin
				cmd.op  = OP_MSPLIT;
				state_d = ST_YR4;
			end
			ST_YR4: begin
				cmd.op = OP_YR4;
				if (!sts.yr4_more)
					state_d = ST_YR1;
			end
			ST_YR1: begin
				cmd.op = OP_YR1;
				if (!sts.yr1_more)
					state_d = ST_MON;
			end
			ST_MON: begin
				cmd.op = OP_MON;
				if (!sts.mon_more)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: src/e2lc_dp.sv
// ----------------------------------------------------------------------------
// e2lc_dp - conversion datapath
// Offset register, reciprocal day divide, reciprocal time split, year and
// month walkers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module e2lc_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic signed [e2lc_pkg::OFFSET_W-1:0] cfg_offset,
	input  wire logic signed [e2lc_pkg::EPOCH_W-1:0]  epoch_seconds,
	input  wire e2lc_pkg::e2lc_cmd_t               cmd,
	output e2lc_pkg::e2lc_sts_t                    sts,
	output logic [e2lc_pkg::YEAR_W-1:0]            year,
	output logic [e2lc_pkg::MONTH_W-1:0]           month,
	output logic [e2lc_pkg::MDAY_W-1:0]            day_of_month,
	output logic [e2lc_pkg::HOUR_W-1:0]            hour,
	output logic [e2lc_pkg::MIN_W-1:0]             minute,
	output logic [e2lc_pkg::SEC_W-1:0]             second,
	output logic [e2lc_pkg::WDAY_W-1:0]            weekday,
	output logic [e2lc_pkg::YDAY_W-1:0]            day_of_year
);
	import e2lc_pkg::*;

	logic signed [OFFSET_W-1:0] off_q;

	logic [NUM_W-1:0]   num_q;
	logic [DPROD_W-1:0] dprod_q;
	logic [WPROD_W-1:0] wprod_q;
	logic [SOD_W-1:0]   rem_q;
	logic [DAYS_W-1:0]  days_q;
	logic [2:0]         mod7_q;
	logic [HPROD_W-1:0] hprod_q;
	logic [MPROD_W-1:0] mprod_q;
	logic [SOH_W-1:0]   soh_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   min_q;
	logic [SEC_W-1:0]   sec_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [YDAY_W-1:0]  yday_q;

	logic [YEAR_W-1:0]  o_year_q;
	logic [MONTH_W-1:0] o_month_q;
	logic [MDAY_W-1:0]  o_mday_q;
	logic [HOUR_W-1:0]  o_hour_q;
	logic [MIN_W-1:0]   o_min_q;
	logic [SEC_W-1:0]   o_sec_q;
	logic [WDAY_W-1:0]  o_wday_q;
	logic [YDAY_W-1:0]  o_yday_q;

	logic [33:0]        biased;
	logic [DAYS_W-1:0]  days_c;
	logic [NUM_W-1:0]   day_secs;
	logic [WQ_W-1:0]    wq_c;
	logic [DAYS_W-1:0]  week_days;
	logic [3:0]         wd_sum;
	logic [HOUR_W-1:0]  hour_c;
	logic [MIN_W-1:0]   min_c;
	logic [SOD_W-1:0]   hour_secs;
	logic [SOH_W-1:0]   min_secs;
	logic               leap;
	logic [YDAY_W-1:0]  ylen;
	logic [MDAY_W-1:0]  mlen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			off_q <= OFFSET_RESET;
		else if (cfg_we)
			off_q <= cfg_offset;
	end

	// bias to 1901-01-01 so the divide only ever sees a positive count
	assign biased = {{2{epoch_seconds[EPOCH_W-1]}}, epoch_seconds}
		+ {{(34-OFFSET_W){off_q[OFFSET_W-1]}}, off_q} + EPOCH_BIAS;

	assign days_c    = dprod_q[DAY_SHIFT +: DAYS_W];
	assign day_secs  = NUM_W'(days_c) * NUM_W'(SEC_PER_DAY);
	assign wq_c      = wprod_q[WDAY_SHIFT +: WQ_W];
	assign week_days = DAYS_W'(wq_c) * DAYS_PER_WEEK;
	assign wd_sum    = {1'b0, mod7_q} + {1'b0, BASE_WEEKDAY};

	assign hour_c    = hprod_q[HOUR_SHIFT +: HOUR_W];
	assign hour_secs = SOD_W'(hour_c) * SEC_PER_HOUR;
	assign min_c     = mprod_q[MIN_SHIFT +: MIN_W];
	assign min_secs  = SOH_W'(min_c) * SEC_PER_MIN;

	// every year 1901..2099 that divides by four is a leap year, 2000 included
	assign leap = (year_q[1:0] == 2'b00);
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = month_len(month_q, leap);

	assign sts.yr4_more = (days_q >= DAYS_PER_4Y);
	assign sts.yr1_more = (days_q >= DAYS_W'(ylen));
	assign sts.mon_more = (month_q != LAST_MONTH) && (days_q >= DAYS_W'(mlen));

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				num_q   <= biased[NUM_W-1:0];
				year_q  <= BASE_YEAR;
				month_q <= '0;
			end
			OP_DMUL: begin
				dprod_q <= DPROD_W'(num_q[NUM_W-1:DAY_PRESHIFT]) * DPROD_W'(DAY_RECIP);
			end
			OP_DSPLIT: begin
				days_q <= days_c;
				rem_q  <= SOD_W'(num_q - day_secs);
			end
			OP_HMUL: begin
				hprod_q <= HPROD_W'(rem_q) * HPROD_W'(HOUR_RECIP);
				wprod_q <= WPROD_W'(days_q) * WPROD_W'(WDAY_RECIP);
			end
			OP_HSPLIT: begin
				hour_q <= hour_c;
				soh_q  <= SOH_W'(rem_q - hour_secs);
				mod7_q <= WDAY_W'(days_q - week_days);
			end
			OP_MMUL: begin
				mprod_q <= MPROD_W'(soh_q) * MPROD_W'(MIN_RECIP);
			end
			OP_MSPLIT: begin
				min_q <= min_c;
				sec_q <= SEC_W'(soh_q - min_secs);
			end
			OP_YR4: begin
				if (sts.yr4_more) begin
					days_q <= days_q - DAYS_PER_4Y;
					year_q <= year_q + YEAR_W'(4);
				end
			end
			OP_YR1: begin
				if (sts.yr1_more) begin
					days_q <= days_q - DAYS_W'(ylen);
					year_q <= year_q + 1'b1;
				end else begin
					yday_q <= days_q[YDAY_W-1:0];
				end
			end
			OP_MON: begin
				if (sts.mon_more) begin
					days_q  <= days_q - DAYS_W'(mlen);
					month_q <= month_q + 1'b1;
				end
			end
			OP_OUT: begin
				o_year_q  <= year_q;
				o_month_q <= month_q;
				o_mday_q  <= days_q[MDAY_W-1:0] + 1'b1;
				o_hour_q  <= hour_q;
				o_min_q   <= min_q;
				o_sec_q   <= sec_q;
				o_wday_q  <= (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
				o_yday_q  <= yday_q;
			end
			default: begin
			end
		endcase
	end

	assign year         = o_year_q;
	assign month        = o_month_q;
	assign day_of_month = o_mday_q;
	assign hour         = o_hour_q;
	assign minute       = o_min_q;
	assign second       = o_sec_q;
	assign weekday      = o_wday_q;
	assign day_of_year  = o_yday_q;

endmodule

`default_nettype wire

FILE: src/epoch_to_local_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_to_local_calendar_top - epoch seconds to local calendar time
// Channels: cfg_ch writes the signed UTC offset in seconds (always ready,
// only to be written while the block is idle); in_ch takes a signed 32-bit
// count of seconds since 1970-01-01 UTC; out_ch returns year, month,
// day_of_month, hour, minute, second, weekday and day_of_year.
// One result word per input word. From input acceptance to result valid a
// word passes through the reciprocal divide by a day, the time split, the
// four-year steps, the single-year steps, the month steps and the hand-off
// into the output register. The year and month walkers make this time
// depend on the date. One word is converted at a time; in_ch is ready
// again in the cycle in which the result goes valid.
// The result sits in an output register, so a new word may be taken while
// a result waits; if the receiver stalls, the next conversion holds in its
// final step until the register is free.
// Reset clears the sequencer and output valid and sets the offset to +8 h.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_local_calendar_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	e2lc_cfg_if.sink   cfg_ch,
	e2lc_in_if.sink    in_ch,
	e2lc_out_if.source out_ch
);
	import e2lc_pkg::*;

	e2lc_cmd_t cmd;
	e2lc_sts_t sts;

	assign cfg_ch.ready = 1'b1;

	e2lc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	e2lc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_ch.valid),
		.cfg_offset    (cfg_ch.utc_offset_seconds),
		.epoch_seconds (in_ch.epoch_seconds),
		.cmd           (cmd),
		.sts           (sts),
		.year          (out_ch.year),
		.month         (out_ch.month),
		.day_of_month  (out_ch.day_of_month),
		.hour          (out_ch.hour),
		.minute        (out_ch.minute),
		.second        (out_ch.second),
		.weekday       (out_ch.weekday),
		.day_of_year   (out_ch.day_of_year)
	);

endmodule

`default_nettype wire
